[design/sine_cosine_taylor_defines.svh]
// ----------------------------------------------------------------------------
// sine_cosine_taylor_defines
// Assertion macros for the sine / cosine series pipeline.
// ----------------------------------------------------------------------------
`ifndef SINE_COSINE_TAYLOR_DEFINES_SVH
`define SINE_COSINE_TAYLOR_DEFINES_SVH
`ifndef SYNTH
// Clocked check, masked while reset is high
`define SCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs during reset
`define SCT_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCT_ASSERT(lbl, clk, rst, prop, msg)
`define SCT_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

[design/sct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Fixed-point constants, widths and rounding helpers for the sine / cosine
// series pipeline.
// ----------------------------------------------------------------------------
package sct_pkg;

   // Number of reciprocals held in the divisor table
   localparam int MAX_TERMS = 10;

   // Angle constants, 2^-32 rad units
   localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
   localparam logic [33:0] PI_Q32      = 34'd13493037705;
   localparam logic [34:0] TAU_Q32     = 35'd26986075409;

   // floor(2^62 / TAU_Q32), used to estimate the turn count
   localparam logic [27:0] TAU_RECIP   = 28'd170891318;

   // Largest reduced magnitude, 2^-30 rad units
   localparam logic [31:0] PI_Q30      = 32'd3373259426;

   // One in Q30
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

   // round(2^32 / ((2n-1)(2n))) for n = 1..10
   localparam logic [31:0] RECIP_Q32 [MAX_TERMS] = '{
      32'd2147483648, 32'd357913941, 32'd143165577, 32'd76695845, 32'd47721859,
      32'd32537631,   32'd23598721,  32'd17895697,  32'd14035841, 32'd11302546
   };

   // Data types of the series section
   typedef logic [33:0]        x2_type;    // x^2, Q30
   typedef logic [32:0]        tmag_type;  // term magnitude or step gain, Q30
   typedef logic [65:0]        prod_type;  // full product of two Q30 values
   typedef logic signed [35:0] sum_type;   // running series sum, Q30

   // Round half-up and drop 32 fraction bits
   function automatic tmag_type round_q32(input prod_type p);
      logic [66:0] s;
      s = {1'b0, p} + (67'd1 << 31);
      return s[64:32];
   endfunction

   // Round half-up and drop 30 fraction bits
   function automatic tmag_type round_q30(input prod_type p);
      logic [66:0] s;
      s = {1'b0, p} + (67'd1 << 29);
      return s[62:30];
   endfunction

endpackage

[design/sine_cosine_taylor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_taylor
// Cosine or sine of a Q15.16 angle by range reduction and a Taylor series,
// result in Q1.30 saturated to plus or minus one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: req_action picks cosine (0) or sine (1), req_angle is
//   the angle in radians, signed Q15.16. Result channel rsp_*: rsp_value is
//   the cosine or sine, signed Q1.30, within [-1.0, +1.0].
//   Throughput: one item per cycle while the result side does not stall;
//   every stage is a register and each series term takes one multiply
//   stage and one rounding stage.
//   The angle is reduced modulo 2*pi with a reciprocal multiply and a
//   one-step correction, then folded into [0, pi] since cosine is even.
//   Stall: while rsp_ready is low with a result waiting, the whole pipeline
//   holds; req_ready is high while it advances or the first stage is empty.
//   Reset clears all valid bits; the block keeps no other state.
// ----------------------------------------------------------------------------
`include "sine_cosine_taylor_defines.svh"

module sine_cosine_taylor #(
   parameter int SERIES_TERMS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value
);

   localparam int DEPTH  = 13 + 2 * SERIES_TERMS;
   localparam int ST_R1  = 4;
   localparam int ST_M   = 6;
   localparam int ST_FIN = 11 + 2 * SERIES_TERMS;

   // Stage enables
   logic             adv;
   logic             en0;
   logic [DEPTH-1:0] v_ff;

   assign adv       = ~v_ff[DEPTH-1] | rsp_ready;
   assign en0       = adv | ~v_ff[0];
   assign req_ready = en0;
   assign rsp_valid = v_ff[DEPTH-1];

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en0) begin
            v_ff[0] <= req_valid;
         end
         if (adv) begin
            v_ff[DEPTH-1:1] <= v_ff[DEPTH-2:0];
         end
      end
   end

   // ---------------------------------------------------------------
   // Range reduction
   // ---------------------------------------------------------------
   logic signed [48:0] a_in, a_ff, a2_ff, a3_ff;
   logic signed [55:0] q_prod;
   logic signed [15:0] q_in, q_ff;
   logic signed [51:0] qt_prod;
   logic signed [50:0] qt_in, qt_ff;
   logic signed [50:0] r0_full;
   logic signed [36:0] r0_in, r0_ff;
   logic signed [36:0] tau_s;
   logic signed [36:0] r1_full;
   logic [34:0]        r1_in, r1_ff;
   logic [34:0]        fold;
   logic [33:0]        mag_in, mag_ff;
   logic [34:0]        m_sum;
   logic [31:0]        m_in, m_ff;
   logic [63:0]        pm_in, pm_ff;
   logic [64:0]        x2_sum;
   sct_pkg::x2_type    x2_in, x2_ff;

   always_comb begin
      // Widen to Q32 and shift sine by a quarter turn
      a_in = {req_angle[31], req_angle, 16'b0}
           - (req_action ? {16'b0, sct_pkg::HALF_PI_Q32} : 49'd0);

      // Estimate the turn count from the upper angle bits
      q_prod = $signed(a_ff[48:22]) * $signed({1'b0, sct_pkg::TAU_RECIP});
      q_in   = q_prod[55:40];

      qt_prod = q_ff * $signed({1'b0, sct_pkg::TAU_Q32});
      qt_in   = qt_prod[50:0];

      r0_full = {{2{a3_ff[48]}}, a3_ff} - qt_ff;
      r0_in   = r0_full[36:0];

      // Correct the estimate by at most one turn either way
      tau_s = $signed({2'b0, sct_pkg::TAU_Q32});
      if (r0_ff < 0) begin
         r1_full = r0_ff + tau_s;
      end else if (r0_ff >= tau_s) begin
         r1_full = r0_ff - tau_s;
      end else begin
         r1_full = r0_ff;
      end
      r1_in = r1_full[34:0];

      // Fold into [0, pi]; exactly pi stays
      fold = sct_pkg::TAU_Q32 - r1_ff;
      if (r1_ff > {1'b0, sct_pkg::PI_Q32}) begin
         mag_in = fold[33:0];
      end else begin
         mag_in = r1_ff[33:0];
      end

      m_sum = {1'b0, mag_ff} + 35'd2;
      m_in  = m_sum[33:2];

      pm_in  = {32'b0, m_ff} * {32'b0, m_ff};
      x2_sum = {1'b0, pm_ff} + (65'd1 << 29);
      x2_in  = x2_sum[63:30];
   end

   // Hold the first stage when full and stalled
   always_ff @(posedge clock) begin
      if (en0) begin
         a_ff <= a_in;
      end
   end

   // Advance the reduction stages
   always_ff @(posedge clock) begin
      if (adv) begin
         a2_ff  <= a_ff;
         q_ff   <= q_in;
         a3_ff  <= a2_ff;
         qt_ff  <= qt_in;
         r0_ff  <= r0_in;
         r1_ff  <= r1_in;
         mag_ff <= mag_in;
         m_ff   <= m_in;
         pm_ff  <= pm_in;
         x2_ff  <= x2_in;
      end
   end

   // ---------------------------------------------------------------
   // Series: one multiply stage and one rounding stage per term
   // ---------------------------------------------------------------
   sct_pkg::prod_type pg_ff  [0:SERIES_TERMS-1];
   sct_pkg::x2_type   x2a_ff [0:SERIES_TERMS-1];
   sct_pkg::x2_type   x2b_ff [0:SERIES_TERMS-1];
   sct_pkg::tmag_type g_ff   [0:SERIES_TERMS-1];
   sct_pkg::prod_type pt_ff  [1:SERIES_TERMS];
   sct_pkg::sum_type  sa_ff  [1:SERIES_TERMS];
   sct_pkg::tmag_type tm_ff  [0:SERIES_TERMS];
   sct_pkg::sum_type  sb_ff  [0:SERIES_TERMS];

   // Seed: first step gain, unit term and unit sum
   always_ff @(posedge clock) begin
      if (adv) begin
         pg_ff[0]  <= {32'b0, x2_ff} * {34'b0, sct_pkg::RECIP_Q32[0]};
         x2a_ff[0] <= x2_ff;
         g_ff[0]   <= sct_pkg::round_q32(pg_ff[0]);
         x2b_ff[0] <= x2a_ff[0];
         tm_ff[0]  <= 33'(sct_pkg::ONE_Q30);
         sb_ff[0]  <= 36'(sct_pkg::ONE_Q30);
      end
   end

   for (genvar n = 1; n <= SERIES_TERMS; n++) begin : g_cell
      sct_pkg::prod_type pt_in;
      sct_pkg::sum_type  sa_in;
      sct_pkg::tmag_type tm_in;

      assign pt_in = {33'b0, tm_ff[n-1]} * {33'b0, g_ff[n-1]};
      assign tm_in = sct_pkg::round_q30(pt_ff[n]);

      // Add the previous term; odd terms are negative
      if (n == 1) begin : g_first
         assign sa_in = sb_ff[0];
      end else if (n % 2 == 0) begin : g_sub
         assign sa_in = sb_ff[n-1] - $signed({3'b0, tm_ff[n-1]});
      end else begin : g_add
         assign sa_in = sb_ff[n-1] + $signed({3'b0, tm_ff[n-1]});
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pt_ff[n] <= pt_in;
            sa_ff[n] <= sa_in;
            tm_ff[n] <= tm_in;
            sb_ff[n] <= sa_ff[n];
         end
      end

      // Prepare the next step gain alongside
      if (n < SERIES_TERMS) begin : g_gain
         sct_pkg::prod_type pg_in;
         sct_pkg::tmag_type g_in;

         assign pg_in = {32'b0, x2b_ff[n-1]} * {34'b0, sct_pkg::RECIP_Q32[n]};
         assign g_in  = sct_pkg::round_q32(pg_ff[n]);

         always_ff @(posedge clock) begin
            if (adv) begin
               pg_ff[n]  <= pg_in;
               x2a_ff[n] <= x2b_ff[n-1];
               g_ff[n]   <= g_in;
               x2b_ff[n] <= x2a_ff[n];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Last term, saturation and output register
   // ---------------------------------------------------------------
   sct_pkg::sum_type   sf_in, sf_ff;
   logic signed [31:0] value_in, value_ff;

   always_comb begin
      if (SERIES_TERMS % 2 == 1) begin
         sf_in = sb_ff[SERIES_TERMS] - $signed({3'b0, tm_ff[SERIES_TERMS]});
      end else begin
         sf_in = sb_ff[SERIES_TERMS] + $signed({3'b0, tm_ff[SERIES_TERMS]});
      end

      // Clamp to plus or minus one
      if (sf_ff > 36'(sct_pkg::ONE_Q30)) begin
         value_in = sct_pkg::ONE_Q30;
      end else if (sf_ff < -36'(sct_pkg::ONE_Q30)) begin
         value_in = -sct_pkg::ONE_Q30;
      end else begin
         value_in = sf_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sf_ff    <= sf_in;
         value_ff <= value_in;
      end
   end

   assign rsp_value = value_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `SCT_ASSERT_RST(a_rst_empty, clock, reset |=> !rsp_valid, "result valid after reset")
   `SCT_ASSERT(a_turn_range, clock, reset, v_ff[ST_R1] |-> r1_ff < sct_pkg::TAU_Q32,
      "reduced angle outside one turn")
   `SCT_ASSERT(a_fold_range, clock, reset, v_ff[ST_M] |-> m_ff <= sct_pkg::PI_Q30,
      "folded magnitude above pi")
   `SCT_ASSERT(a_out_range, clock, reset,
      rsp_valid |-> (rsp_value <= sct_pkg::ONE_Q30 && rsp_value >= -sct_pkg::ONE_Q30),
      "result beyond unit range")
   `SCT_ASSERT(a_hold_fin, clock, reset,
      (v_ff[ST_FIN] && !adv) |=> (v_ff[ST_FIN] && $stable(sf_ff)),
      "final sum changed while stalled")

endmodule

[tb/sv/sine_cosine_taylor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_taylor_tb
// Self-checking bench for the sine / cosine series pipeline. Items go in
// through the req_ handshake, and a bit-exact fixed-point model computes the
// Q1.30 value that each one must produce. Results are checked in order as
// they leave the rsp_ handshake. Directed corners come first, then a long
// output stall that fills the pipeline, random angles under random idling
// on both sides, and a full drain between bursts.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_tb;

   localparam int NUM_TERMS   = 8;
   localparam int LATENCY     = 12 + 2 * NUM_TERMS;
   localparam int CYCLE_LIMIT = 1000000;

   // Angle constants, 2^-32 rad units
   localparam longint ANG_HALF_PI = 64'sd6746518852;
   localparam longint ANG_PI      = 64'sd13493037705;
   localparam longint ANG_TAU     = 64'sd26986075409;
   localparam longint UNIT_Q30    = 64'sd1073741824;

   // Angles in Q15.16 near the quadrant points
   localparam int Q16_HALF_PI = 102944;
   localparam int Q16_PI      = 205887;

   localparam bit OP_COSINE = 1'b0;
   localparam bit OP_SINE   = 1'b1;

   typedef struct {
      logic               action;
      logic signed [31:0] angle;
      logic signed [31:0] value;
   } trig_item_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_action;
   logic signed [31:0] req_angle;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_value;

   trig_item_type pending_values [$];
   int         fail_count  = 0;
   int         cycle_count = 0;
   bit         sender_gaps = 1'b0;
   bit         sink_idle   = 1'b0;
   int         sink_hold   = 0;
   int         sink_stall  = 0;

   sine_cosine_taylor #(
      .SERIES_TERMS(NUM_TERMS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_action(req_action),
      .req_angle (req_angle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value)
   );

   always #2 clock = ~clock;

   // Rounded product: (a*b + 2^(s-1)) >> s, exact in 128 bits
   function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << (s - 1));
      return 64'(p >> s);
   endfunction

   // round(2^32 / ((2n-1)(2n)))
   function automatic logic [63:0] divisor_recip(int n);
      case (n)
         1:       return 64'd2147483648;
         2:       return 64'd357913941;
         3:       return 64'd143165577;
         4:       return 64'd76695845;
         5:       return 64'd47721859;
         6:       return 64'd32537631;
         7:       return 64'd23598721;
         8:       return 64'd17895697;
         9:       return 64'd14035841;
         default: return 64'd11302546;
      endcase
   endfunction

   // Expected Q1.30 cosine or sine of a Q15.16 angle
   function automatic logic signed [31:0] series_value(logic sine_sel,
                                                       logic signed [31:0] ang);
      longint      a;
      longint      r;
      longint      total;
      logic [63:0] mag;
      logic [63:0] m;
      logic [63:0] x2;
      logic [63:0] tmag;
      logic [63:0] g;
      a = longint'(ang) * 64'sd65536;
      if (sine_sel == OP_SINE)
         a = a - ANG_HALF_PI;
      // floored modulo into [0, 2pi), then into (-pi, pi]
      r = a % ANG_TAU;
      if (r < 0)
         r = r + ANG_TAU;
      if (r > ANG_PI)
         r = r - ANG_TAU;
      mag = (r < 0) ? 64'(-r) : 64'(r);
      m = (mag + 64'd2) >> 2;
      x2 = mul_round(m, m, 30);
      total = UNIT_Q30;
      tmag = 64'(UNIT_Q30);
      for (int n = 1; n <= NUM_TERMS && n <= 10; n++) begin
         g = mul_round(x2, divisor_recip(n), 32);
         tmag = mul_round(tmag, g, 30);
         if (n % 2 == 1)
            total = total - longint'(tmag);
         else
            total = total + longint'(tmag);
      end
      if (total > UNIT_Q30)
         total = UNIT_Q30;
      if (total < -UNIT_Q30)
         total = -UNIT_Q30;
      return total[31:0];
   endfunction

   // Idle length: mostly short, a few long
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return $urandom_range(1, 3);
      else if (pick < 95)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // Record the expected value of each accepted item
   always @(posedge clock) begin : track_inputs
      trig_item_type item;
      if (!reset && req_valid && req_ready) begin
         item.action = req_action;
         item.angle  = req_angle;
         item.value  = series_value(req_action, req_angle);
         pending_values.push_back(item);
      end
   end

   // Compare each accepted result with the oldest pending item
   always @(posedge clock) begin : check_results
      trig_item_type item;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_values.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result: expected none, actual %0d", $time, rsp_value);
         end else begin
            item = pending_values.pop_front();
            if (rsp_value !== item.value) begin
               fail_count++;
               $display("%0t: action %0d angle %0d: expected %0d, actual %0d",
                        $time, item.action, item.angle, item.value, rsp_value);
            end
         end
      end
   end

   // Result side: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (sink_hold > 0) begin
         sink_stall = sink_hold;
         sink_hold  = 0;
      end else if (sink_stall == 0 && sink_idle && $urandom_range(0, 99) < 15) begin
         sink_stall = idle_len();
      end
      if (sink_stall > 0) begin
         rsp_ready <= 1'b0;
         sink_stall--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d items pending", $time, pending_values.size());
         $display("** sine_cosine_taylor: FAILED **");
         $finish;
      end
   end

   // Offer one item, hold it until accepted, then maybe idle
   task automatic send_item(logic action, logic signed [31:0] angle);
      int gap;
      @(negedge clock);
      req_valid  <= 1'b1;
      req_action <= action;
      req_angle  <= angle;
      do
         @(posedge clock);
      while (!req_ready);
      gap = (sender_gaps && $urandom_range(0, 99) < 30) ? idle_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic hold_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_values.size() != 0)
         @(posedge clock);
   endtask

   // Corner angles with both operations
   task automatic test_corners();
      logic signed [31:0] angle;
      sender_gaps = 1'b0;
      sink_idle   = 1'b0;
      for (int i = 0; i < 12; i++) begin
         case (i)
            0:       angle = 32'sd0;
            1:       angle = 32'sd1;
            2:       angle = -32'sd1;
            3:       angle = 32'h7FFF_FFFF;
            4:       angle = 32'h8000_0000;
            5:       angle = Q16_PI;
            6:       angle = Q16_PI + 1;
            7:       angle = -Q16_PI;
            8:       angle = -Q16_PI - 1;
            9:       angle = Q16_HALF_PI;
            10:      angle = 2 * Q16_PI + 1;
            default: angle = 3 * Q16_HALF_PI - 1;
         endcase
         send_item(OP_COSINE, angle);
         send_item(OP_SINE, angle);
      end
   endtask

   // Random angles, idling mode changed per chunk
   task automatic test_random(int count);
      logic signed [31:0] angle;
      int                 pick;
      int                 k;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            pick = $urandom_range(0, 3);
            sender_gaps = pick[0];
            sink_idle   = pick[1];
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            angle = $urandom;
         end else if (pick < 60) begin
            angle = $signed($urandom_range(0, 8 * Q16_PI)) - 4 * Q16_PI;
         end else if (pick < 85) begin
            k = $signed($urandom_range(0, 80)) - 40;
            angle = k * Q16_HALF_PI + $signed($urandom_range(0, 6)) - 3;
         end else begin
            angle = $signed($urandom_range(0, 128)) - 64;
         end
         send_item(1'($urandom_range(0, 1)), angle);
      end
   endtask

   // Long output stall while items keep coming: fills the pipeline
   task automatic test_output_stall();
      sender_gaps = 1'b0;
      sink_idle   = 1'b0;
      sink_hold   = 4 * LATENCY + 50;
      for (int i = 0; i < 80; i++)
         send_item(1'($urandom_range(0, 1)), $urandom);
   endtask

   // Burst, full drain, burst
   task automatic test_drain_pause();
      sender_gaps = 1'b1;
      sink_idle   = 1'b1;
      for (int i = 0; i < 20; i++)
         send_item(1'($urandom_range(0, 1)), $urandom);
      hold_sender();
      wait_drained();
      for (int i = 0; i < 20; i++)
         send_item(1'($urandom_range(0, 1)), $urandom);
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = OP_COSINE;
      req_angle  = 32'sd0;
      rsp_ready  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corners();
      test_output_stall();
      test_random(1000);
      test_drain_pause();
      test_random(1000);

      // Drain and let any stray result show up
      hold_sender();
      sink_idle = 1'b0;
      wait_drained();
      repeat (2 * LATENCY + 8) @(posedge clock);
      if (fail_count == 0 && pending_values.size() == 0) begin
         $display("** sine_cosine_taylor: PASSED **");
      end else begin
         $display("** sine_cosine_taylor: FAILED **");
      end
      $finish;
   end

endmodule
